### sv/pmu_pkg.sv
// Shared constants, types and helpers of the polynomial multiply unit.
package pmu_pkg;

	localparam int MAX_TERMS  = 32;
	localparam int COEFF_BITS = 16;

	localparam int VALUE_W   = 16;
	localparam int INDEX_W   = 5;
	localparam int OPCODE_W  = 2;
	localparam int LEN_W     = 6;
	localparam int POWER_W   = 6;
	localparam int PRODUCT_W = 37;
	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int PROD_W    = 2 * COEFF_BITS;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [OPCODE_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_MULTIPLY    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LEN_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_SECOND = 2'd1;

	typedef logic signed [COEFF_BITS-1:0] coeff_t;
	typedef logic signed [PRODUCT_W-1:0]  acc_t;

	// tags that follow one MAC term down the pipe
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic               tail;   // last term of the highest power
		logic [POWER_W-1:0] k;
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} issue_t;

	// sign-extend a loaded value, then wrap to the coefficient width
	function automatic coeff_t to_coeff(input logic signed [VALUE_W-1:0] v);
		logic signed [63:0] w;
		w = v;
		return w[COEFF_BITS-1:0];
	endfunction

	// product into accumulator width: sign-extend or wrap
	function automatic acc_t fit_prod(input logic signed [PROD_W-1:0] p);
		logic signed [63:0] w;
		w = p;
		return w[PRODUCT_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
		if (n == '0)
			return LEN_W'(1);
		if (n > LEN_W'(MAX_TERMS))
			return LEN_W'(MAX_TERMS);
		return n;
	endfunction

endpackage

### sv/pmu_coeff_store.sv
// Coefficient memories of both polynomials, written by loads, read by the sequencer.
module pmu_coeff_store import pmu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_first,
	input  logic             wr_second,
	input  logic [IDX_W-1:0] wr_idx,
	input  coeff_t           wr_value,
	input  logic             stall,
	input  issue_t           issue,
	output tag_t             tag_s1,
	output coeff_t           a_s1,
	output coeff_t           b_s1
);

	coeff_t mem_first  [MAX_TERMS];
	coeff_t mem_second [MAX_TERMS];

	// loads are taken only while the sequencer is idle, so no read meets a write
	always_ff @(posedge clk) begin
		if (wr_first)
			mem_first[wr_idx] <= wr_value;
		if (wr_second)
			mem_second[wr_idx] <= wr_value;
		if (!stall) begin
			a_s1 <= mem_first[issue.i];
			b_s1 <= mem_second[issue.j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (!stall) begin
			tag_s1 <= issue.tag;
		end
	end

endmodule

### sv/pmu_sequencer.sv
// Term sequencer: walks every (i, k-i) pair of the convolution, one per cycle while not stalled.
module pmu_sequencer import pmu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LEN_W-1:0] len_first,
	input  logic [LEN_W-1:0] len_second,
	input  logic             stall,
	output logic             busy,
	output issue_t           issue
);

	logic               active_q;
	logic [POWER_W-1:0] k_q;
	logic [IDX_W-1:0]   i_q;

	logic [LEN_W-1:0]   n1;
	logic [LEN_W-1:0]   n2;
	logic [POWER_W-1:0] k_final;
	logic [POWER_W-1:0] hi;
	logic [IDX_W-1:0]   lo_cur;
	logic [IDX_W-1:0]   lo_next;
	logic               last_i;
	logic [POWER_W:0]   tot_w;

	// lowest i with k-i below n2
	function automatic logic [IDX_W-1:0] lo_of(input logic [POWER_W:0] kp1,
			input logic [LEN_W-1:0] n);
		logic [POWER_W:0] d;
		d = kp1 - (POWER_W+1)'(n);
		return (kp1 > (POWER_W+1)'(n)) ? d[IDX_W-1:0] : '0;
	endfunction

	always_comb begin
		n1      = clamp_len(len_first);
		n2      = clamp_len(len_second);
		tot_w   = (POWER_W+1)'(n1) + (POWER_W+1)'(n2) - (POWER_W+1)'(2);
		k_final = tot_w[POWER_W-1:0];
		hi      = (k_q < POWER_W'(n1 - LEN_W'(1))) ? k_q : POWER_W'(n1 - LEN_W'(1));
		lo_cur  = lo_of((POWER_W+1)'(k_q) + (POWER_W+1)'(1), n2);
		lo_next = lo_of((POWER_W+1)'(k_q) + (POWER_W+1)'(2), n2);
		last_i  = POWER_W'(i_q) == hi;
	end

	always_comb begin
		issue.tag.valid = active_q;
		issue.tag.first = i_q == lo_cur;
		issue.tag.last  = last_i;
		issue.tag.tail  = last_i && (k_q == k_final);
		issue.tag.k     = k_q;
		issue.i         = i_q;
		issue.j         = IDX_W'(k_q - POWER_W'(i_q));
	end

	assign busy = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
			i_q      <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			k_q      <= '0;
			i_q      <= '0;
		end else if (active_q && !stall) begin
			if (last_i) begin
				if (k_q == k_final) begin
					active_q <= 1'b0;
				end else begin
					k_q <= k_q + POWER_W'(1);
					i_q <= lo_next;
				end
			end else begin
				i_q <= i_q + IDX_W'(1);
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !active_q)
		else $error("multiply started while sequencer busy");

	a_i_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (POWER_W'(i_q) <= hi) && (i_q >= lo_cur))
		else $error("term index outside convolution window");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> k_q <= k_final)
		else $error("power index past last product term");

endmodule

### sv/pmu_mac.sv
// Multiply-accumulate stages and the output word register.
module pmu_mac import pmu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tag_t               tag_s1,
	input  coeff_t             a_s1,
	input  coeff_t             b_s1,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [POWER_W-1:0] out_power,
	output acc_t               out_product,
	output logic               out_last,
	output logic               stall
);

	tag_t                     tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	acc_t                     acc_q;
	acc_t                     sum;
	logic                     out_valid_q;

	// whole pipe freezes while a finished word waits
	assign stall     = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign sum       = (tag_s2.first ? acc_t'(0) : acc_q) + fit_prod(prod_s2);

	always_ff @(posedge clk) begin
		if (!stall) begin
			prod_s2 <= a_s1 * b_s1;
			if (tag_s2.valid) begin
				acc_q <= sum;
				if (tag_s2.last) begin
					out_product <= sum;
					out_power   <= tag_s2.k;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2      <= '0;
			out_valid_q <= 1'b0;
			out_last    <= 1'b0;
		end else if (!stall) begin
			tag_s2      <= tag_s1;
			out_valid_q <= tag_s2.valid && tag_s2.last;
			if (tag_s2.valid && tag_s2.last)
				out_last <= tag_s2.tail;
		end
	end

	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s2.valid && tag_s2.last && !stall) |=> out_valid_q)
		else $error("finished product term not registered");

endmodule

### sv/polynomial_multiply_unit.sv
// Top level of the polynomial multiply unit (linear convolution of two coefficient lists).
//
// channel | dir | handshake           | word
// --------+-----+---------------------+----------------------------------------------
// s_      | in  | s_tvalid / s_tready | tuser opcode, tdata index and coefficient
// m_      | out | m_tvalid / m_tready | tdata power and product, tlast on top power
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data length
//
// A multiply runs one MAC a cycle while the pipe is not stalled: terms are issued
// and pass through the memory read, multiply and accumulate registers, with the
// single read port of each coefficient memory feeding one multiplier.
// s_tready and cfg_ready are low while terms are being issued. A stalled m_ word
// freezes the whole MAC pipe. Reset clears control and sets both lengths to 32;
// the coefficient memories are not cleared and must be loaded before use.
module polynomial_multiply_unit import pmu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // coeff_index [4:0], coeff_value [20:5]
	input  logic [OPCODE_W-1:0]   s_tuser,   // opcode [1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // power_index [5:0], product_value [42:6]
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEN_W-1:0] len_first_q;
	logic [LEN_W-1:0] len_second_q;

	logic               s_accept;
	logic [INDEX_W-1:0] coeff_index;
	logic [VALUE_W-1:0] coeff_value;
	logic               idx_ok;
	logic               wr_first;
	logic               wr_second;
	logic               start;
	logic               busy;
	logic               stall;
	issue_t             issue;
	tag_t               tag_s1;
	coeff_t             a_s1;
	coeff_t             b_s1;
	logic [POWER_W-1:0] out_power;
	acc_t               out_product;
	logic               out_last;

	assign coeff_index = s_tdata[INDEX_W-1:0];
	assign coeff_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

	assign s_tready = !busy;
	assign s_accept = s_tvalid && s_tready;
	// loads past the store depth are dropped
	assign idx_ok    = (INDEX_W+1)'(coeff_index) < (INDEX_W+1)'(MAX_TERMS);
	assign wr_first  = s_accept && (s_tuser == OP_LOAD_FIRST) && idx_ok;
	assign wr_second = s_accept && (s_tuser == OP_LOAD_SECOND) && idx_ok;
	assign start     = s_accept && (s_tuser == OP_MULTIPLY);

	// lengths hold still while the sequencer walks the terms
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_first_q  <= LEN_W'(32);
			len_second_q <= LEN_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEN_FIRST:  len_first_q  <= cfg_data;
				REG_LEN_SECOND: len_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pmu_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.len_first  (len_first_q),
		.len_second (len_second_q),
		.stall      (stall),
		.busy       (busy),
		.issue      (issue)
	);

	pmu_coeff_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_first  (wr_first),
		.wr_second (wr_second),
		.wr_idx    (coeff_index[IDX_W-1:0]),
		.wr_value  (to_coeff(coeff_value)),
		.stall     (stall),
		.issue     (issue),
		.tag_s1    (tag_s1),
		.a_s1      (a_s1),
		.b_s1      (b_s1)
	);

	// last flag rides with the term tag, so it is fixed when the multiply starts
	pmu_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag_s1      (tag_s1),
		.a_s1        (a_s1),
		.b_s1        (b_s1),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_power   (out_power),
		.out_product (out_product),
		.out_last    (out_last),
		.stall       (stall)
	);

	assign m_tlast = out_last;
	assign m_tdata = {5'd0, out_product, out_power};

endmodule

### tb/sv/tb_polynomial_multiply_unit.sv
// Self-checking testbench of polynomial_multiply_unit: loads, multiplies and checks each product.
module tb_polynomial_multiply_unit import pmu_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// opcode and register index that the block must ignore
	localparam logic [OPCODE_W-1:0]  OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int IDLE_PCT   = 34;    // chance in a hundred that a side idles in a cycle
	localparam int SETTLE     = 16;    // cycles allowed after the last word for the MAC pipe
	localparam int WORD_GOAL  = 120;   // loads and multiplies over the whole run
	localparam int REPORT_MAX = 10;
	localparam int LIMIT_NS   = 2_000_000;

	// one input word: opcode in tuser, index and coefficient in tdata
	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic [INDEX_W-1:0]  idx;
		logic [VALUE_W-1:0]  value;
	} stream_word_t;

	// one product coefficient as it should leave the block
	typedef struct {
		logic [POWER_W-1:0]   power;
		logic [PRODUCT_W-1:0] product;
		logic                 last;
	} product_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;   // coeff_index [4:0], coeff_value [20:5]
	logic [OPCODE_W-1:0]   s_tuser   = '0;   // opcode [1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [47:0]           m_tdata;          // power_index [5:0], product_value [42:6]
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	polynomial_multiply_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor state: own copy of both lengths and both stores
	// ---------------------------------------------------------------
	logic [LEN_W-1:0]          len_first_reg  = LEN_W'(32);
	logic [LEN_W-1:0]          len_second_reg = LEN_W'(32);
	logic signed [VALUE_W-1:0] first_store  [MAX_TERMS];
	logic signed [VALUE_W-1:0] second_store [MAX_TERMS];

	product_t     product_q[$];   // products expected, oldest first
	stream_word_t word_queue[$];  // words waiting for the driver
	stream_word_t next_word;
	int           words_left = 0; // queued but not yet accepted
	int           words_sent = 0; // loads and multiplies queued so far
	int           mismatches = 0;
	logic         steady     = 1'b0; // both sides stay busy while set

	// stimulus side bookkeeping: entries written at least once
	bit [MAX_TERMS-1:0] loaded_first  = '0;
	bit [MAX_TERMS-1:0] loaded_second = '0;

	// a length of zero counts as one, anything past the store depth as the depth
	function automatic int eff_len(logic [LEN_W-1:0] n);
		if (n == '0)
			return 1;
		if (int'(n) > MAX_TERMS)
			return MAX_TERMS;
		return int'(n);
	endfunction

	// update the stores for a load, or queue the whole convolution for a multiply
	function automatic void apply_word(logic [OPCODE_W-1:0] op, logic [23:0] data);
		int n1, n2, k, i;
		longint acc;
		product_t p;
		n1 = eff_len(len_first_reg);
		n2 = eff_len(len_second_reg);
		case (op)
			OP_LOAD_FIRST:  first_store[data[4:0]]  = data[20:5];
			OP_LOAD_SECOND: second_store[data[4:0]] = data[20:5];
			OP_MULTIPLY: begin
				for (k = 0; k < n1 + n2 - 1; k++) begin
					acc = 0;
					for (i = 0; i < n1; i++)
						if (k >= i && k - i < n2)
							acc += longint'(first_store[i]) * longint'(second_store[k - i]);
					p.power   = POWER_W'(k);
					p.product = acc[PRODUCT_W-1:0];
					p.last    = (k == n1 + n2 - 2);
					product_q.push_back(p);
				end
			end
			default: ;   // unused opcode: nothing happens
		endcase
	endfunction

	function automatic void report_product(string why, product_t exp_p, product_t got_p);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t ns: %s: exp %0d/%0d/%0b got %0d/%0d/%0b (power/product/last)",
				$time, why, exp_p.power, $signed(exp_p.product), exp_p.last,
				got_p.power, $signed(got_p.product), got_p.last);
	endfunction

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Driver: presents queued words, idles at random between them.
	// A word is handed to the predictor at the edge that accepts it.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(s_tuser, s_tdata);
				words_left--;
			end
			if (!s_tvalid || s_tready) begin
				if (word_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					next_word = word_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_word.op;
					s_tdata  <= {3'b000, next_word.value, next_word.idx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, compares each accepted word
	// with the oldest expected product
	// ---------------------------------------------------------------
	product_t seen_p;
	product_t want_p;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_p.power   = m_tdata[5:0];
				seen_p.product = m_tdata[42:6];
				seen_p.last    = m_tlast;
				if (product_q.size() == 0) begin
					want_p = '{default: '0};
					report_product("unexpected product", want_p, seen_p);
				end else begin
					want_p = product_q.pop_front();
					if (want_p.power !== seen_p.power || want_p.product !== seen_p.product ||
							want_p.last !== seen_p.last)
						report_product("product mismatch", want_p, seen_p);
				end
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_word(stream_word_t w);
		word_queue.push_back(w);
		words_left++;
		if (w.op == OP_LOAD_FIRST)
			loaded_first[w.idx] = 1'b1;
		if (w.op == OP_LOAD_SECOND)
			loaded_second[w.idx] = 1'b1;
		if (w.op != OP_UNUSED)
			words_sent++;
	endtask

	// wait until every word is taken and every product has come out
	task automatic drain();
		do
			@(posedge clk);
		while (words_left != 0 || product_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write; cfg_valid is left high for a following write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_LEN_FIRST)
			len_first_reg = data;
		else if (idx == REG_LEN_SECOND)
			len_second_reg = data;
	endtask

	// lengths change only with the block idle
	task automatic set_lengths(logic [LEN_W-1:0] la, logic [LEN_W-1:0] lb, bit poke_unused);
		drain();
		write_reg(REG_LEN_FIRST, la);
		if (poke_unused)
			write_reg(REG_UNUSED, '1);
		write_reg(REG_LEN_SECOND, lb);
		cfg_valid <= 1'b0;
	endtask

	// extremes show up often so that the sums reach their bounds
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'hffff;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(9))
			0:       return '0;
			1:       return LEN_W'(1);
			2:       return LEN_W'(32);
			3:       return LEN_W'($urandom_range(63, 33));
			default: return LEN_W'($urandom_range(31, 2));
		endcase
	endfunction

	// fill every entry the multiply will read that was never written,
	// add a few random reloads and maybe an unused opcode, shuffle, multiply
	task automatic load_and_multiply(int extra);
		stream_word_t batch[$];
		stream_word_t w;
		int n1, n2, i, j;
		n1 = eff_len(len_first_reg);
		n2 = eff_len(len_second_reg);
		for (i = 0; i < MAX_TERMS; i++) begin
			w.idx   = INDEX_W'(i);
			w.value = pick_value();
			if (i < n1 && !loaded_first[i]) begin
				w.op = OP_LOAD_FIRST;
				batch.push_back(w);
			end
			if (i < n2 && !loaded_second[i]) begin
				w.op = OP_LOAD_SECOND;
				batch.push_back(w);
			end
		end
		repeat (extra) begin
			w.op    = $urandom_range(1) ? OP_LOAD_SECOND : OP_LOAD_FIRST;
			w.idx   = INDEX_W'($urandom);
			w.value = pick_value();
			batch.push_back(w);
		end
		if ($urandom_range(3) == 0) begin
			w.op    = OP_UNUSED;
			w.idx   = INDEX_W'($urandom);
			w.value = VALUE_W'($urandom);
			batch.push_back(w);
		end
		for (i = batch.size() - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			w        = batch[i];
			batch[i] = batch[j];
			batch[j] = w;
		end
		foreach (batch[b])
			queue_word(batch[b]);
		// index and value mean nothing to a multiply, so they carry noise
		w.op    = OP_MULTIPLY;
		w.idx   = INDEX_W'($urandom);
		w.value = VALUE_W'($urandom);
		queue_word(w);
	endtask

	// ---------------------------------------------------------------
	// Sequence: reset, directed corners, two long full-size jobs with
	// no idling, then random lengths and random contents
	// ---------------------------------------------------------------
	stream_word_t dw;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-term polynomials; an unused register is written once too
		set_lengths(LEN_W'(1), LEN_W'(1), 1'b1);
		dw = '{op: OP_UNUSED, idx: '1, value: '1};
		queue_word(dw);
		dw = '{op: OP_LOAD_FIRST, idx: '0, value: 16'h8000};
		queue_word(dw);
		dw = '{op: OP_LOAD_SECOND, idx: '0, value: 16'h8000};
		queue_word(dw);
		dw = '{op: OP_MULTIPLY, idx: '1, value: '1};      // most negative squared
		queue_word(dw);
		dw = '{op: OP_LOAD_SECOND, idx: '0, value: 16'h7fff};
		queue_word(dw);
		dw = '{op: OP_MULTIPLY, idx: '0, value: '0};
		queue_word(dw);
		// top index, outside the current lengths
		dw = '{op: OP_LOAD_FIRST, idx: '1, value: 16'h7fff};
		queue_word(dw);
		dw = '{op: OP_LOAD_SECOND, idx: '1, value: 16'h0000};
		queue_word(dw);
		dw = '{op: OP_LOAD_FIRST, idx: '0, value: 16'h0000};
		queue_word(dw);
		dw = '{op: OP_MULTIPLY, idx: 5'h15, value: 16'h5555};
		queue_word(dw);

		// zero length acts as one
		set_lengths('0, LEN_W'(2), 1'b0);
		dw = '{op: OP_LOAD_SECOND, idx: 5'd1, value: 16'h8000};
		queue_word(dw);
		dw = '{op: OP_LOAD_FIRST, idx: '0, value: 16'h7fff};
		queue_word(dw);
		dw = '{op: OP_MULTIPLY, idx: 5'h0a, value: 16'haaaa};
		queue_word(dw);

		// full size: length past the depth on one side, the depth on the other
		steady <= 1'b1;
		set_lengths(LEN_W'(63), LEN_W'(32), 1'b0);
		load_and_multiply(0);
		load_and_multiply(4);
		drain();
		steady <= 1'b0;

		while (words_sent < WORD_GOAL) begin
			set_lengths(pick_len(), pick_len(), 1'b0);
			repeat ($urandom_range(3, 1))
				load_and_multiply($urandom_range(6));
		end

		drain();
		while (product_q.size() != 0) begin
			want_p = product_q.pop_front();
			seen_p = '{default: '0};
			report_product("missing product", want_p, seen_p);
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
